[src/kfp_pkg.sv]
// ----------------------------------------------------------------------------
// kfp_pkg: shared types and constants for the keyframe pose player
// Opcodes, fixed field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package kfp_pkg;

  localparam int POSE_W = 48;
  localparam int KEY_W  = 32;
  localparam int STEP_W = 16;
  localparam int NUM_OUT_CH = 11;
  localparam logic [STEP_W-1:0] STEPS_RESET = 16'd800;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SAVE   = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_ADJUST = 3'd4
  } opcode_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SAVE = 8'b0000_0010,
    ST_LOAD = 8'b0000_0100,
    ST_RDA  = 8'b0000_1000,
    ST_RDB  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_STEP = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

endpackage

[src/kfp_ram.sv]
// ----------------------------------------------------------------------------
// kfp_ram: generic simple dual-port RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module kfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 352
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/keyframe_pose_player.sv]
// ----------------------------------------------------------------------------
// keyframe_pose_player: pose recorder and linear keyframe player
// Holds a pose, records keyframes to RAM and plays them back by interpolation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high. Adjust, clear and idle ticks
// go straight to the result. A playing tick adds increments one channel
// per cycle. Save writes one channel per cycle.
// A toggle that starts play, or a tick that opens a new segment, reads both
// keyframes from the store and runs a bit-serial restoring divider per
// channel. The divider produces one quotient bit per cycle. The receiver
// cannot stall results. The keyframe store needs no clearing pass after reset.
module keyframe_pose_player
  import kfp_pkg::*;
#(
  parameter int MAX_KEYFRAMES = 32,
  parameter int CHANNELS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [STEP_W-1:0]  cfg_wdata,
  input  logic [2:0]         opcode,
  input  logic [3:0]         channel,
  input  logic signed [31:0] delta,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] yaw,
  output logic signed [31:0] head_angle,
  output logic signed [31:0] tail_angle,
  output logic signed [31:0] front_left_angle,
  output logic signed [31:0] front_right_angle,
  output logic signed [31:0] rear_angle,
  output logic signed [31:0] pitch,
  output logic signed [31:0] roll,
  output logic               playing
);

  localparam int DEPTH = MAX_KEYFRAMES * CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FW    = $clog2(MAX_KEYFRAMES + 1);
  localparam int SW    = (MAX_KEYFRAMES > 2) ? $clog2(MAX_KEYFRAMES) : 1;
  // dividend magnitude: |d|<2^33, shifted by 16 -> 49 bits
  localparam int DVW   = 49;
  localparam int DCW   = $clog2(DVW + 1);

  state_t state;

  logic [STEP_W-1:0] steps_reg;
  logic [POSE_W-1:0] pose [CHANNELS];
  logic [POSE_W-1:0] incr [CHANNELS];
  logic [FW-1:0]     frame_count;
  logic [SW-1:0]     segment;
  logic [STEP_W-1:0] step_count;
  logic              play_flag;

  logic [CW-1:0]     ch;
  logic              is_load;  // toggle start: also load pose from frame 0

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, base_a;
  logic [KEY_W-1:0]  ram_wdata, ram_rdata, key_a;

  // divider
  logic [DVW-1:0]    dv_q;    // dividend shifting out, quotient shifting in
  logic [STEP_W:0]   dv_rem;
  logic              dv_neg;
  logic [DCW-1:0]    dv_cnt;
  logic [STEP_W-1:0] eff_steps;
  logic [STEP_W:0]   dv_trial;
  logic [STEP_W:0]   rem_shift;

  logic [31:0]       pose_hi [CHANNELS];

  assign eff_steps = (steps_reg == '0) ? STEP_W'(1) : steps_reg;
  assign base_a    = AW'(segment) * AW'(CHANNELS);
  assign ram_waddr = AW'(frame_count) * AW'(CHANNELS) + AW'(ch);
  assign ram_wdata = pose_hi[ch];
  assign ram_we    = (state == ST_SAVE);
  assign rem_shift = {dv_rem[STEP_W-1:0], dv_q[DVW-1]};
  assign dv_trial  = rem_shift - {1'b0, eff_steps};

  always_comb begin
    ram_raddr = base_a + AW'(ch);
    if (state == ST_RDA) begin
      ram_raddr = base_a + AW'(CHANNELS) + AW'(ch);
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_hi
    assign pose_hi[g] = pose[g][POSE_W-1:16];
  end

  kfp_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_reg <= STEPS_RESET;
    end else if (cfg_we) begin
      steps_reg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [KEY_W:0] diff;
    logic [DVW-1:0]        mag;
    logic [POSE_W-1:0]     qv;
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= '0;
      segment     <= '0;
      step_count  <= '0;
      play_flag   <= 1'b0;
      ch          <= '0;
      is_load     <= 1'b0;
      dv_cnt      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pose[i] <= '0;
        incr[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          ch <= '0;
          if (start) begin
            state <= ST_DONE;
            case (opcode)
              OP_TICK: begin
                if (play_flag) begin
                  if (step_count >= eff_steps) begin
                    // segment end: advance or stop
                    if (32'(segment) + 32'd3 > 32'(frame_count)) begin
                      segment   <= '0;
                      play_flag <= 1'b0;
                    end else begin
                      segment    <= segment + SW'(1);
                      step_count <= '0;
                      is_load    <= 1'b0;
                      state      <= ST_LOAD;
                    end
                  end else begin
                    step_count <= step_count + STEP_W'(1);
                    state      <= ST_STEP;
                  end
                end
              end
              OP_SAVE: begin
                if (32'(frame_count) < 32'(MAX_KEYFRAMES)) begin
                  state <= ST_SAVE;
                end
              end
              OP_TOGGLE: begin
                if (!play_flag && frame_count > FW'(1)) begin
                  segment    <= '0;
                  step_count <= '0;
                  is_load    <= 1'b1;
                  play_flag  <= 1'b1;
                  state      <= ST_LOAD;
                end else begin
                  play_flag <= 1'b0;
                end
              end
              OP_CLEAR: begin
                for (int i = 0; i < CHANNELS; i++) begin
                  pose[i] <= '0;
                end
                frame_count <= '0;
                play_flag   <= 1'b0;
              end
              OP_ADJUST: begin
                for (int i = 0; i < CHANNELS; i++) begin
                  if (32'(channel) == i) begin
                    pose[i] <= pose[i] + {delta, 16'd0};
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_SAVE: begin
          // write one channel per cycle
          if (32'(ch) == CHANNELS - 1) begin
            frame_count <= frame_count + FW'(1);
            state       <= ST_DONE;
          end else begin
            ch <= ch + CW'(1);
          end
        end
        ST_STEP: begin
          pose[ch] <= pose[ch] + incr[ch];
          if (32'(ch) == CHANNELS - 1) begin
            state <= ST_DONE;
          end else begin
            ch <= ch + CW'(1);
          end
        end
        ST_LOAD: begin
          // read of current-frame entry issued this cycle
          state <= ST_RDA;
        end
        ST_RDA: begin
          key_a <= ram_rdata;
          if (is_load) begin
            pose[ch] <= {ram_rdata, 16'd0};
          end
          state <= ST_RDB;
        end
        ST_RDB: begin
          diff   = $signed({ram_rdata[KEY_W-1], ram_rdata})
                 - $signed({key_a[KEY_W-1], key_a});
          dv_neg <= diff[KEY_W];
          mag    = diff[KEY_W] ? DVW'(-diff) : DVW'(diff);
          dv_q   <= mag << 16;
          dv_rem <= '0;
          dv_cnt <= DCW'(DVW);
          state  <= ST_DIV;
        end
        ST_DIV: begin
          // one restoring step per cycle
          if (dv_cnt == '0) begin
            qv = dv_neg ? POSE_W'(-dv_q) : POSE_W'(dv_q);
            incr[ch] <= qv;
            if (32'(ch) == CHANNELS - 1) begin
              state <= ST_DONE;
            end else begin
              ch    <= ch + CW'(1);
              state <= ST_LOAD;
            end
          end else begin
            dv_cnt <= dv_cnt - DCW'(1);
            if (!dv_trial[STEP_W]) begin
              dv_rem <= dv_trial;
              dv_q   <= {dv_q[DVW-2:0], 1'b1};
            end else begin
              dv_rem <= rem_shift;
              dv_q   <= {dv_q[DVW-2:0], 1'b0};
            end
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  // channels beyond the configured count read as zero
  function automatic logic [31:0] chan_out(input int idx, input logic [31:0] v);
    return (idx < CHANNELS) ? v : 32'd0;
  endfunction

  assign pos_x             = chan_out(0, pose_hi[0]);
  assign pos_y             = chan_out(1, pose_hi[(CHANNELS > 1) ? 1 : 0]);
  assign pos_z             = chan_out(2, pose_hi[(CHANNELS > 2) ? 2 : 0]);
  assign yaw               = chan_out(3, pose_hi[(CHANNELS > 3) ? 3 : 0]);
  assign head_angle        = chan_out(4, pose_hi[(CHANNELS > 4) ? 4 : 0]);
  assign tail_angle        = chan_out(5, pose_hi[(CHANNELS > 5) ? 5 : 0]);
  assign front_left_angle  = chan_out(6, pose_hi[(CHANNELS > 6) ? 6 : 0]);
  assign front_right_angle = chan_out(7, pose_hi[(CHANNELS > 7) ? 7 : 0]);
  assign rear_angle        = chan_out(8, pose_hi[(CHANNELS > 8) ? 8 : 0]);
  assign pitch             = chan_out(9, pose_hi[(CHANNELS > 9) ? 9 : 0]);
  assign roll              = chan_out(10, pose_hi[(CHANNELS > 10) ? 10 : 0]);
  assign playing           = play_flag;

endmodule

[src/kfp_checker.sv]
// ----------------------------------------------------------------------------
// kfp_checker: port-level checks for the keyframe pose player
// Watches the request and result handshake.
// ----------------------------------------------------------------------------
module kfp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic playing
);

  // an accepted request raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");

  // a result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

  // done only while busy, then the block frees
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !busy) else $error("done outside request");

  // play state changes only when a request is taken
  a_play_stable: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> $stable(playing)) else $error("playing moved");

endmodule

bind keyframe_pose_player kfp_checker u_kfp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .playing(playing)
);

[test/keyframe_pose_player_check.sv]
// ----------------------------------------------------------------------------
// keyframe_pose_player_check: prediction and comparison for the pose player
// Follows every accepted request and register write with its own copy of the
// pose, keyframe table and playback state, and compares each result against
// the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module keyframe_pose_player_check
  import kfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic               cfg_we,
  input  logic [STEP_W-1:0]  cfg_wdata,
  input  logic [2:0]         opcode,
  input  logic [3:0]         channel,
  input  logic signed [31:0] delta,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] yaw,
  input  logic signed [31:0] head_angle,
  input  logic signed [31:0] tail_angle,
  input  logic signed [31:0] front_left_angle,
  input  logic signed [31:0] front_right_angle,
  input  logic signed [31:0] rear_angle,
  input  logic signed [31:0] pitch,
  input  logic signed [31:0] roll,
  input  logic               playing,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES = 32;
  localparam int NCH = NUM_OUT_CH;

  typedef struct {
    logic [31:0] chan [NCH];
    logic        playing;
  } pose_result_t;

  logic [POSE_W-1:0] pose_acc [NCH];
  logic [POSE_W-1:0] pose_inc [NCH];
  logic [KEY_W-1:0]  frames [NFRAMES*NCH];
  int unsigned       frame_count, segment, step_count, steps;
  logic              play_on;
  pose_result_t      pose_queue [$];

  function automatic int unsigned eff_steps();
    return (steps == 0) ? 1 : steps;
  endfunction

  function automatic void load_increments();
    longint diff, quot;
    for (int c = 0; c < NCH; c++) begin
      diff = longint'($signed(frames[(segment+1)*NCH + c]))
           - longint'($signed(frames[segment*NCH + c]));
      quot = (diff * 65536) / longint'(eff_steps());
      pose_inc[c] = quot[POSE_W-1:0];
    end
  endfunction

  function automatic void apply_request(logic [2:0] op, logic [3:0] ch,
                                        logic [31:0] dv);
    pose_result_t r;
    case (op)
      OP_TICK: begin
        if (play_on) begin
          if (step_count >= eff_steps()) begin
            segment++;
            if (segment + 2 > frame_count) begin
              segment = 0;
              play_on = 1'b0;
            end else begin
              step_count = 0;
              load_increments();
            end
          end else begin
            for (int c = 0; c < NCH; c++) pose_acc[c] = pose_acc[c] + pose_inc[c];
            step_count++;
          end
        end
      end
      OP_SAVE: begin
        if (frame_count < NFRAMES) begin
          for (int c = 0; c < NCH; c++) frames[frame_count*NCH + c] = pose_acc[c][47:16];
          frame_count++;
        end
      end
      OP_TOGGLE: begin
        if (!play_on && frame_count > 1) begin
          for (int c = 0; c < NCH; c++) pose_acc[c] = {frames[c], 16'h0};
          segment = 0;
          step_count = 0;
          load_increments();
          play_on = 1'b1;
        end else begin
          play_on = 1'b0;
        end
      end
      OP_CLEAR: begin
        for (int c = 0; c < NCH; c++) pose_acc[c] = '0;
        frame_count = 0;
        play_on = 1'b0;
      end
      OP_ADJUST: begin
        if (ch < NCH) pose_acc[ch] = pose_acc[ch] + {dv, 16'h0};
      end
      default: ;
    endcase
    for (int c = 0; c < NCH; c++) r.chan[c] = pose_acc[c][47:16];
    r.playing = play_on;
    pose_queue.push_back(r);
  endfunction

  function automatic void report(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic void check_result();
    pose_result_t want;
    logic [31:0] got [NCH];
    got = '{pos_x, pos_y, pos_z, yaw, head_angle, tail_angle, front_left_angle,
            front_right_angle, rear_angle, pitch, roll};
    if (pose_queue.size() == 0) begin
      errors++;
      if (errors <= 10) $display("mismatch: result with nothing outstanding");
      return;
    end
    want = pose_queue.pop_front();
    for (int c = 0; c < NCH; c++)
      if (got[c] !== want.chan[c]) report($sformatf("channel %0d", c), want.chan[c], got[c]);
    if (playing !== want.playing) report("playing", want.playing, playing);
  endfunction

  initial errors = 0;
  assign pending = pose_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        pose_acc[c] = '0;
        pose_inc[c] = '0;
      end
      frame_count = 0;
      segment = 0;
      step_count = 0;
      steps = STEPS_RESET;
      play_on = 1'b0;
      pose_queue.delete();
    end else begin
      if (done) check_result();
      if (cfg_we) steps = cfg_wdata;
      if (start && !busy) apply_request(opcode, channel, delta);
    end
  end

endmodule

[test/keyframe_pose_player_test.sv]
// ----------------------------------------------------------------------------
// keyframe_pose_player_test: stimulus and verdict for the pose player
// Drives directed and random command streams across several segment lengths,
// with random gaps, while a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module keyframe_pose_player_test;
  import kfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int QUIET_FROM  = 850;   // no gaps once this many requests are in

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic cfg_we = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;
  logic [2:0] opcode = OP_TICK;
  logic [3:0] channel = '0;
  logic signed [31:0] delta = '0;
  logic signed [31:0] pos_x, pos_y, pos_z, yaw, head_angle, tail_angle;
  logic signed [31:0] front_left_angle, front_right_angle, rear_angle, pitch, roll;
  logic playing;
  int errors, pending;
  int sent = 0;
  int cycles = 0;

  keyframe_pose_player dut (.*);
  keyframe_pose_player_check checker_i (.*);

  always #4 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Issue one request and hold it until the block takes it. An idle burst
  // drops start first, so start never gets two updates in one step.
  task automatic issue(logic [2:0] op, logic [3:0] ch, logic [31:0] dv);
    if (sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    opcode  <= op;
    channel <= ch;
    delta   <= dv;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drain everything outstanding, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_steps(int unsigned value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[STEP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_delta();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'h8000_0000 | $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 2**20)) - 2**19;
    endcase
  endfunction

  // Record a short animation, play some of it and then make some noise.
  task automatic play_sequence(int unsigned seg_len);
    int nframes, nticks;
    nframes = $urandom_range(2, 5);
    issue(OP_CLEAR, 4'd0, 32'd0);
    for (int f = 0; f < nframes; f++) begin
      repeat ($urandom_range(1, 3))
        issue(OP_ADJUST, 4'($urandom_range(0, 10)), rand_delta());
      issue(OP_SAVE, 4'd0, 32'd0);
    end
    issue(OP_TOGGLE, 4'd0, 32'd0);
    nticks = (seg_len + 1) * (nframes - 1) + 3;
    if (nticks > 40) nticks = $urandom_range(10, 40);
    for (int t = 0; t < nticks; t++) begin
      if ($urandom_range(0, 9) == 0)
        issue(OP_ADJUST, 4'($urandom_range(0, 15)), rand_delta());
      else issue(OP_TICK, 4'd0, 32'd0);
    end
    repeat ($urandom_range(0, 3))
      issue(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), rand_delta());
  endtask

  initial begin
    int unsigned seg_lens [6] = '{800, 1, 65535, 3, 2, 5};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, unused codes, short table, play and stop.
    issue(OP_ADJUST, 4'd0, 32'h7FFF_FFFF);
    issue(OP_ADJUST, 4'd10, 32'h8000_0000);
    issue(OP_ADJUST, 4'd15, 32'h1234_5678);
    issue(OP_ADJUST, 4'd11, 32'hFFFF_FFFF);
    issue(3'd5, 4'd0, 32'h0);
    issue(3'd7, 4'd15, 32'hFFFF_FFFF);
    issue(OP_TICK, 4'd0, 32'd0);
    issue(OP_SAVE, 4'd0, 32'd0);
    issue(OP_TOGGLE, 4'd0, 32'd0);
    issue(OP_ADJUST, 4'd0, 32'h8000_0001);
    issue(OP_ADJUST, 4'd5, 32'h0001_0000);
    issue(OP_SAVE, 4'd0, 32'd0);
    issue(OP_TOGGLE, 4'd0, 32'd0);
    issue(OP_TICK, 4'd0, 32'd0);
    issue(OP_ADJUST, 4'd3, 32'hFFFF_0000);
    issue(OP_TICK, 4'd0, 32'd0);
    issue(OP_TOGGLE, 4'd0, 32'd0);
    issue(OP_TICK, 4'd0, 32'd0);
    issue(OP_CLEAR, 4'd0, 32'd0);
    issue(OP_TOGGLE, 4'd0, 32'd0);

    // Random phases, one per segment length.
    foreach (seg_lens[i]) begin
      if (i != 0) write_steps(seg_lens[i]);
      // Fill the table past its end once, then play the full set.
      if (seg_lens[i] == 1) begin
        issue(OP_CLEAR, 4'd0, 32'd0);
        for (int f = 0; f < 34; f++) begin
          issue(OP_ADJUST, 4'($urandom_range(0, 10)), rand_delta());
          issue(OP_SAVE, 4'd0, 32'd0);
        end
        issue(OP_TOGGLE, 4'd0, 32'd0);
        repeat (66) issue(OP_TICK, 4'd0, 32'd0);
      end
      while (sent < 150 * (i + 1)) play_sequence(seg_lens[i]);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
